>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/dlgf_pkg.sv
// Types and constants of the depth line gap fill block.
package dlgf_pkg;

  localparam int DEPTH_W = 16;
  localparam int GAP_W = 7;
  localparam int CNT_W = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int DEF_MAX_GAP_LIMIT = 64;
  localparam int DEF_DEPTH_BITS = 16;

  typedef enum logic [0:0] {
    REG_FILL_ENABLE = 1'b0,
    REG_MAX_GAP     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             fill_enable;
    logic [GAP_W-1:0] lim;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   zeros;
    logic               fill;
    logic               has_px;
    logic               last;
    logic [DEPTH_W-1:0] anchor;
    logic [DEPTH_W-1:0] px;
    logic [GAP_W-1:0]   gap_len;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZERO,
    BK_DIV,
    BK_FILL,
    BK_PIX
  } bk_state_t;

endpackage

>>> src/dlgf_front.sv
// Front end: tracks anchor and held zeros, turns pixels into commands; zeros held inside a gap push none.
module dlgf_front #(
  parameter int DEPTH_BITS = dlgf_pkg::DEF_DEPTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dlgf_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dlgf_pkg::DEPTH_W-1:0] depth_in,
  input  logic                         line_end,
  input  logic                         q_full,
  output logic                         push,
  output dlgf_pkg::cmd_t               cmd
);
  import dlgf_pkg::*;

  logic               anchor_valid_r, anchor_valid_nxt;
  logic [DEPTH_W-1:0] anchor_value_r, anchor_value_nxt;
  logic [CNT_W-1:0]   zero_count_r, zero_count_nxt;

  logic [DEPTH_W-1:0] px;
  logic [CNT_W-1:0]   cnt1;
  logic [GAP_W-1:0]   cnt1_dist;
  logic [GAP_W-1:0]   gap_len;

  assign in_ready  = !q_full;
  assign px        = DEPTH_W'(depth_in[DEPTH_BITS-1:0]);
  assign cnt1      = zero_count_r + CNT_W'(1);
  assign cnt1_dist = GAP_W'(cnt1) + GAP_W'(1);
  assign gap_len   = GAP_W'(zero_count_r) + GAP_W'(1);

  always_comb begin
    anchor_valid_nxt = anchor_valid_r;
    anchor_value_nxt = anchor_value_r;
    zero_count_nxt   = zero_count_r;
    push             = 1'b0;
    cmd.zeros        = '0;
    cmd.fill         = 1'b0;
    cmd.has_px       = 1'b0;
    cmd.last         = line_end;
    cmd.anchor       = anchor_value_r;
    cmd.px           = px;
    cmd.gap_len      = gap_len;
    if (in_valid && in_ready) begin
      push = 1'b1;
      if (!cfg.fill_enable) begin
        cmd.zeros        = zero_count_r;
        cmd.has_px       = 1'b1;
        anchor_valid_nxt = 1'b0;
        zero_count_nxt   = '0;
      end else if (px == '0) begin
        if (!anchor_valid_r) begin
          cmd.zeros      = zero_count_r;
          cmd.has_px     = 1'b1;
          zero_count_nxt = '0;
        end else if (line_end || cnt1_dist >= cfg.lim) begin
          cmd.zeros        = cnt1;
          anchor_valid_nxt = 1'b0;
          zero_count_nxt   = '0;
        end else begin
          push           = 1'b0;
          zero_count_nxt = cnt1;
        end
      end else begin
        if (anchor_valid_r && gap_len > GAP_W'(1) && gap_len < cfg.lim) begin
          cmd.fill = 1'b1;
        end else begin
          cmd.zeros = zero_count_r;
        end
        cmd.has_px       = 1'b1;
        anchor_valid_nxt = 1'b1;
        anchor_value_nxt = px;
        zero_count_nxt   = '0;
      end
      if (line_end) begin
        anchor_valid_nxt = 1'b0;
        zero_count_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_valid_r <= 1'b0;
      zero_count_r   <= '0;
    end else begin
      anchor_valid_r <= anchor_valid_nxt;
      zero_count_r   <= zero_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    anchor_value_r <= anchor_value_nxt;
  end

endmodule

>>> src/dlgf_fifo.sv
// Small command queue between front and back end.
module dlgf_fifo #(
  parameter int DEPTH = dlgf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dlgf_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dlgf_pkg::cmd_t cmd_out
);
  import dlgf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> src/dlgf_div.sv
// Restoring divider for the gradient: floor division of a signed difference by the gap.
module dlgf_div #(
  parameter int DW = dlgf_pkg::DEF_DEPTH_BITS,
  parameter int GW = dlgf_pkg::GAP_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] mag,
  input  logic          neg,
  input  logic [GW-1:0] divisor,
  output logic          done,
  output logic [DW:0]   qd,
  output logic [GW-1:0] rd
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [GW-1:0] rem_r;
  logic [GW-1:0] dsr_r;
  logic          neg_r;

  logic [GW:0]   rem_sh;
  logic          ge;
  logic [GW:0]   rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign done    = done_r;

  always_comb begin
    if (!neg_r) begin
      qd = {1'b0, dvd_r};
      rd = rem_r;
    end else if (rem_r != '0) begin
      qd = ~{1'b0, dvd_r};
      rd = dsr_r - rem_r;
    end else begin
      qd = ~{1'b0, dvd_r} + (DW + 1)'(1);
      rd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= mag;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= neg;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? rem_sub[GW-1:0] : rem_sh[GW-1:0];
    end
  end

endmodule

>>> src/dlgf_back.sv
// Back end: plays out zero runs, interpolated runs and pixels into the output register.
module dlgf_back #(
  parameter int DEPTH_BITS = dlgf_pkg::DEF_DEPTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  dlgf_pkg::cmd_t               q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dlgf_pkg::DEPTH_W-1:0] out_depth_out,
  output logic                         out_was_filled,
  output logic                         out_line_last,
  output logic                         out_run_last
);
  import dlgf_pkg::*;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   zcnt_r, zcnt_nxt;
  logic [GAP_W-1:0]   left_r, left_nxt;
  logic [DEPTH_W-1:0] q_r, q_nxt;
  logic [GAP_W-1:0]   r_r, r_nxt;
  logic [DEPTH_W:0]   qd_r, qd_nxt;
  logic [GAP_W-1:0]   rd_r, rd_nxt;

  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_filled_r, out_line_r, out_run_r;

  logic               can_emit, emit;
  logic [DEPTH_W-1:0] emit_depth;
  logic               emit_filled, emit_line, emit_run;

  logic [DEPTH_W:0]      diff;
  logic [DEPTH_W:0]      diff_mag;
  logic                  div_start, div_done;
  logic [DEPTH_BITS:0]   div_qd;
  logic [GAP_W-1:0]      div_rd;

  logic [GAP_W:0]     r_sum, r_sub;
  logic               wrap;
  logic [DEPTH_W:0]   q_sum;

  assign diff     = {1'b0, q_head.px} - {1'b0, q_head.anchor};
  assign diff_mag = diff[DEPTH_W] ? (~diff + (DEPTH_W + 1)'(1)) : diff;

  dlgf_div #(
    .DW (DEPTH_BITS),
    .GW (GAP_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (diff_mag[DEPTH_BITS-1:0]),
    .neg     (diff[DEPTH_W]),
    .divisor (q_head.gap_len),
    .done    (div_done),
    .qd      (div_qd),
    .rd      (div_rd)
  );

  assign r_sum = {1'b0, r_r} + {1'b0, rd_r};
  assign wrap  = r_sum >= {1'b0, cmd_r.gap_len};
  assign r_sub = r_sum - {1'b0, cmd_r.gap_len};
  assign q_sum = {1'b0, q_r} + qd_r + {{DEPTH_W{1'b0}}, wrap};

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    zcnt_nxt    = zcnt_r;
    left_nxt    = left_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    qd_nxt      = qd_r;
    rd_nxt      = rd_r;
    pop         = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_depth  = '0;
    emit_filled = 1'b0;
    emit_line   = 1'b0;
    emit_run    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_nxt  = q_head;
          zcnt_nxt = q_head.zeros;
          if (q_head.zeros != '0) begin
            state_nxt = BK_ZERO;
          end else if (q_head.fill) begin
            div_start = 1'b1;
            state_nxt = BK_DIV;
          end else begin
            state_nxt = BK_PIX;
          end
        end
      end
      BK_ZERO: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_run  = (zcnt_r == CNT_W'(1)) && !cmd_r.has_px;
          emit_line = emit_run && cmd_r.last;
          zcnt_nxt  = zcnt_r - CNT_W'(1);
          if (zcnt_r == CNT_W'(1)) begin
            state_nxt = cmd_r.has_px ? BK_PIX : BK_IDLE;
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          q_nxt     = cmd_r.anchor;
          r_nxt     = '0;
          qd_nxt    = (DEPTH_W + 1)'($signed(div_qd));
          rd_nxt    = div_rd;
          left_nxt  = cmd_r.gap_len - GAP_W'(1);
          state_nxt = BK_FILL;
        end
      end
      BK_FILL: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_depth  = q_sum[DEPTH_W-1:0];
          emit_filled = 1'b1;
          q_nxt       = q_sum[DEPTH_W-1:0];
          r_nxt       = wrap ? r_sub[GAP_W-1:0] : r_sum[GAP_W-1:0];
          left_nxt    = left_r - GAP_W'(1);
          if (left_r == GAP_W'(1)) begin
            state_nxt = BK_PIX;
          end
        end
      end
      BK_PIX: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_depth = cmd_r.px;
          emit_run   = 1'b1;
          emit_line  = cmd_r.last;
          state_nxt  = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    zcnt_r <= zcnt_nxt;
    left_r <= left_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    qd_r   <= qd_nxt;
    rd_r   <= rd_nxt;
    if (emit) begin
      out_depth_r  <= emit_depth;
      out_filled_r <= emit_filled;
      out_line_r   <= emit_line;
      out_run_r    <= emit_run;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_depth_out  = out_depth_r;
  assign out_was_filled = out_filled_r;
  assign out_line_last  = out_line_r;
  assign out_run_last   = out_run_r;

endmodule

>>> src/depth_line_gap_fill.sv
// Top level of the depth line gap fill block: registers, front end, queue, back end.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_depth_in, in_line_end
//   out     | output    | out_valid / out_ready| out_depth_out, out_was_filled,
//           |           |                      | out_line_last, out_run_last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front end takes one pixel per cycle while the four-entry command queue is not full.
// The back end pops a command only in its idle state, then emits its results one per cycle
// while the output is not stalled; a filled gap of dist first waits for the serial divider,
// then emits its dist - 1 fill values before the pixel.
// Reset is synchronous; state and config registers are reset and the queue is empty after it.
// A stalled output holds the back end; the front end stalls once the queue is full.
module depth_line_gap_fill #(
  parameter int MAX_GAP_LIMIT = dlgf_pkg::DEF_MAX_GAP_LIMIT,
  parameter int DEPTH_BITS    = dlgf_pkg::DEF_DEPTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dlgf_pkg::DEPTH_W-1:0] in_depth_in,
  input  logic                         in_line_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dlgf_pkg::DEPTH_W-1:0] out_depth_out,
  output logic                         out_was_filled,
  output logic                         out_line_last,
  output logic                         out_run_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [dlgf_pkg::GAP_W-1:0]   cfg_data
);
  import dlgf_pkg::*;

  logic             fill_enable_r;
  logic [GAP_W-1:0] max_gap_r;
  cfg_t             cfg;

  logic q_full, q_empty, push, pop;
  cmd_t cmd_in, cmd_head;

  assign cfg_ready       = 1'b1;
  assign cfg.fill_enable = fill_enable_r;
  assign cfg.lim         = (max_gap_r < GAP_W'(MAX_GAP_LIMIT)) ? max_gap_r
                                                                : GAP_W'(MAX_GAP_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_enable_r <= 1'b0;
      max_gap_r     <= GAP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FILL_ENABLE: fill_enable_r <= cfg_data[0];
        REG_MAX_GAP:     max_gap_r     <= cfg_data;
      endcase
    end
  end

  dlgf_front #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .depth_in (in_depth_in),
    .line_end (in_line_end),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd_in)
  );

  dlgf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .cmd_out (cmd_head)
  );

  dlgf_back #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (cmd_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_depth_out  (out_depth_out),
    .out_was_filled (out_was_filled),
    .out_line_last  (out_line_last),
    .out_run_last   (out_run_last)
  );

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_line_last_ends_run, clk, rst_n, out_valid && out_line_last, out_run_last)
  `ASSERT_IMPLY(a_fill_not_last, clk, rst_n, out_valid && out_was_filled, !out_run_last)
  `ASSERT_IMPLY(a_fill_nonzero, clk, rst_n, out_valid && out_was_filled, out_depth_out != '0)
  `ASSERT_NEXT(a_fill_then_more, clk, rst_n, out_valid && out_ready && out_was_filled, out_valid)

endmodule
